// ===== src/vif_pkg.sv =====
// shared types, constants and helpers of the vertical interpolation filter
package vif_pkg;

	localparam int MAX_WIDTH_DEF = 64;
	localparam int MAX_TAPS_DEF  = 8;
	localparam int SAMPLE_W      = 16;
	localparam int COEFF_W       = 8;
	localparam int PROD_W        = SAMPLE_W + COEFF_W;
	localparam int ACC_W         = 28;
	localparam int OUT_DEPTH     = 8;

	localparam logic [0:0]  TAP_MODE_RST     = 1'b0;
	localparam logic [31:0] COEFF_LOW_RST    = 32'h0000_4000;
	localparam logic [31:0] COEFF_HIGH_RST   = 32'h0000_0000;
	localparam logic [3:0]  ROUND_SHIFT_RST  = 4'd12;
	localparam logic [21:0] ROUND_OFFSET_RST = 22'd526336;
	localparam logic [6:0]  LINE_WIDTH_RST   = 7'd64;

	typedef enum logic [2:0] {
		REG_TAP_MODE     = 3'd0,
		REG_COEFF_LOW    = 3'd1,
		REG_COEFF_HIGH   = 3'd2,
		REG_ROUND_SHIFT  = 3'd3,
		REG_ROUND_OFFSET = 3'd4,
		REG_LINE_WIDTH   = 3'd5
	} vif_reg_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} vif_cell_ctl_t;

	typedef struct packed {
		logic       row_end;
		logic [5:0] column;
		logic [7:0] pixel;
	} vif_res_t;

	function automatic logic signed [COEFF_W-1:0] coeff_byte(
		input logic [63:0] words,
		input logic [2:0]  idx
	);
		logic signed [COEFF_W-1:0] b;
		b = words[{idx, 3'b000} +: COEFF_W];
		return b;
	endfunction

endpackage

// ===== src/vertical_interp_filter_to_pixel.sv =====
// top level of the vertical interpolation filter from intermediate samples to pixels
//
//  channel   dir  handshake              payload
//  s_        in   s_tvalid / s_tready    s_tdata = sample, s_tuser = block_start
//  m_        out  m_tvalid / m_tready    m_tdata = pixel, column; m_tlast = row_end
//  apb       in   psel, penable, pready  paddr, pwdata, pwrite, prdata
//
//  one item is taken per cycle while s_tready is high; the line cells do one read
//  and one write of their row memory per cycle, which sets that rate
//  a pixel passes the stage registers s1 to s4 and then the output queue before m_
//  s_tready falls only while eight results are in flight or queued, i.e. when the
//  output side stalls; the filter pipeline itself never stops
//  reset clears counters, pipeline valid bits, the queue and the registers; the
//  line store is not cleared, a block refills it before any pixel is made
module vertical_interp_filter_to_pixel #(
	parameter int MAX_WIDTH = vif_pkg::MAX_WIDTH_DEF,
	parameter int MAX_TAPS  = vif_pkg::MAX_TAPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	input  logic        s_tuser,   // [0] block_start
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] pixel, [13:8] column, [15:14] zero
	output logic        m_tlast,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import vif_pkg::*;

	localparam int NCELL   = MAX_TAPS - 1;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_TAPS);
	localparam int TAP_W   = $clog2(MAX_TAPS + 1);
	localparam int W_W     = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W   = (W_W > 7) ? W_W : 7;
	localparam int TAPS_HI = (MAX_TAPS < 8) ? MAX_TAPS : 8;
	localparam int NGRP    = (MAX_TAPS + 3) / 4;
	localparam int CNT_W   = $clog2(OUT_DEPTH + 1);

	// configuration registers
	logic        tap_mode_q;
	logic [31:0] coeff_low_q;
	logic [31:0] coeff_high_q;
	logic [3:0]  round_shift_q;
	logic [21:0] round_offset_q;
	logic [6:0]  line_width_q;

	logic        cfg_wr;
	vif_reg_t    cfg_reg;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_reg = vif_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_mode_q     <= TAP_MODE_RST;
			coeff_low_q    <= COEFF_LOW_RST;
			coeff_high_q   <= COEFF_HIGH_RST;
			round_shift_q  <= ROUND_SHIFT_RST;
			round_offset_q <= ROUND_OFFSET_RST;
			line_width_q   <= LINE_WIDTH_RST;
		end else if (cfg_wr) begin
			unique case (cfg_reg)
				REG_TAP_MODE:     tap_mode_q     <= pwdata[0];
				REG_COEFF_LOW:    coeff_low_q    <= pwdata;
				REG_COEFF_HIGH:   coeff_high_q   <= pwdata;
				REG_ROUND_SHIFT:  round_shift_q  <= pwdata[3:0];
				REG_ROUND_OFFSET: round_offset_q <= pwdata[21:0];
				REG_LINE_WIDTH:   line_width_q   <= pwdata[6:0];
				default: ;  // addresses past the list are ignored
			endcase
		end
	end

	always_comb begin
		unique case (cfg_reg)
			REG_TAP_MODE:     prdata = {31'b0, tap_mode_q};
			REG_COEFF_LOW:    prdata = coeff_low_q;
			REG_COEFF_HIGH:   prdata = coeff_high_q;
			REG_ROUND_SHIFT:  prdata = {28'b0, round_shift_q};
			REG_ROUND_OFFSET: prdata = {10'b0, round_offset_q};
			REG_LINE_WIDTH:   prdata = {25'b0, line_width_q};
			default:          prdata = '0;
		endcase
	end

	// tap count, per-cell coeffs: user keeps them static while items flow; unenforced
	logic [TAP_W-1:0]          taps;
	logic [63:0]               coeff_words;
	logic signed [COEFF_W-1:0] cell_coeff [NCELL];
	logic                      cell_used  [NCELL];
	logic signed [COEFF_W-1:0] smp_coeff;

	assign taps        = tap_mode_q ? TAP_W'(TAPS_HI) : TAP_W'(4);
	assign coeff_words = {coeff_high_q, coeff_low_q};
	assign smp_coeff   = coeff_byte(coeff_words, 3'(int'(taps) - 1));

	// cell r holds the row r+1 rows back, which meets tap taps-2-r
	always_comb begin
		for (int r = 0; r < NCELL; r++) begin
			cell_used[r]  = (r + 2) <= int'(taps);
			cell_coeff[r] = coeff_byte(coeff_words, 3'(int'(taps) - 2 - r));
		end
	end

	// input side: column and row tracking
	logic             s_accept;
	logic [COL_W-1:0] column_count_q;
	logic [ROW_W-1:0] row_count_q;
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] rows;
	logic [CMP_W-1:0] width_eff;
	logic             last;
	logic             produce;

	assign s_accept = s_tvalid && s_tready;
	assign col      = s_tuser ? '0 : column_count_q;
	assign rows     = s_tuser ? '0 : row_count_q;

	// a width of zero acts as one, beyond the store it acts as the store width
	always_comb begin
		if (line_width_q == '0) begin
			width_eff = CMP_W'(1);
		end else if (CMP_W'(line_width_q) > CMP_W'(MAX_WIDTH)) begin
			width_eff = CMP_W'(MAX_WIDTH);
		end else begin
			width_eff = CMP_W'(line_width_q);
		end
	end

	assign last    = (CMP_W'(col) + CMP_W'(1)) >= width_eff;
	assign produce = (int'(rows) + 1) >= int'(taps);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (s_accept) begin
			if (last) begin
				column_count_q <= '0;
				if (int'(rows) < MAX_TAPS - 1) begin
					row_count_q <= rows + ROW_W'(1);
				end else begin
					row_count_q <= rows;
				end
			end else begin
				column_count_q <= col + COL_W'(1);
				row_count_q    <= rows;
			end
		end
	end

	// pipeline control: result flags per stage
	logic res_s1, res_s2, res_s3, res_s4;
	logic valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_s1   <= 1'b0;
			res_s2   <= 1'b0;
			res_s3   <= 1'b0;
			res_s4   <= 1'b0;
		end else begin
			valid_s1 <= s_accept;
			res_s1   <= s_accept && produce;
			res_s2   <= res_s1;
			res_s3   <= res_s2;
			res_s4   <= res_s3;
		end
	end

	// pipeline payload
	logic [COL_W-1:0]           col_s1, col_s2, col_s3, col_s4;
	logic                       last_s1, last_s2, last_s3, last_s4;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [PROD_W-1:0]   smp_prod_s2;

	always_ff @(posedge clk) begin
		if (s_accept) begin
			col_s1    <= col;
			last_s1   <= last;
			sample_s1 <= s_tdata;
		end
		col_s2      <= col_s1;
		last_s2     <= last_s1;
		col_s3      <= col_s2;
		last_s3     <= last_s2;
		col_s4      <= col_s3;
		last_s4     <= last_s3;
		smp_prod_s2 <= smp_coeff * sample_s1;
	end

	// chain of line cells: read at accept, each row passes its old value down one row
	vif_cell_ctl_t              cell_ctl;
	logic signed [SAMPLE_W-1:0] cell_rd   [NCELL];
	logic signed [SAMPLE_W-1:0] cell_wr   [NCELL];
	logic signed [PROD_W-1:0]   cell_prod [NCELL];

	assign cell_ctl.rd = s_accept;
	assign cell_ctl.wr = valid_s1;

	always_comb begin
		cell_wr[0] = sample_s1;
		for (int r = 1; r < NCELL; r++) begin
			cell_wr[r] = cell_rd[r-1];
		end
	end

	for (genvar r = 0; r < NCELL; r++) begin : g_cell
		vif_cell #(
			.MAX_WIDTH (MAX_WIDTH)
		) u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.rd_addr  (col),
			.wr_addr  (col_s1),
			.wr_data  (cell_wr[r]),
			.coeff    (cell_coeff[r]),
			.tap_used (cell_used[r]),
			.rd_data  (cell_rd[r]),
			.prod_s2  (cell_prod[r])
		);
	end

	// products of all taps: the cells, then the new sample on the last slot
	logic signed [PROD_W-1:0] prod_all [MAX_TAPS];
	logic signed [ACC_W-1:0]  grp_next [NGRP];
	logic signed [ACC_W-1:0]  grp_s3   [NGRP];
	logic signed [ACC_W-1:0]  acc_next;
	logic signed [ACC_W-1:0]  acc_s4;

	always_comb begin
		for (int r = 0; r < NCELL; r++) begin
			prod_all[r] = cell_prod[r];
		end
		prod_all[MAX_TAPS-1] = smp_prod_s2;
	end

	// partial sums over groups of four taps
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_next[g] = '0;
			for (int j = 0; j < 4; j++) begin
				if (4 * g + j < MAX_TAPS) begin
					grp_next[g] = grp_next[g] + ACC_W'(prod_all[4*g+j]);
				end
			end
		end
	end

	// final sum with the rounding offset
	always_comb begin
		acc_next = ACC_W'(round_offset_q);
		for (int g = 0; g < NGRP; g++) begin
			acc_next = acc_next + grp_s3[g];
		end
	end

	always_ff @(posedge clk) begin
		grp_s3 <= grp_next;
		acc_s4 <= acc_next;
	end

	// shift toward minus infinity and clamp to a byte
	logic signed [ACC_W-1:0] shifted;
	vif_res_t                res_word;

	assign shifted = acc_s4 >>> round_shift_q;

	always_comb begin
		if (shifted < 0) begin
			res_word.pixel = 8'd0;
		end else if (shifted > ACC_W'(255)) begin
			res_word.pixel = 8'd255;
		end else begin
			res_word.pixel = shifted[7:0];
		end
		res_word.column  = 6'(col_s4);
		res_word.row_end = last_s4;
	end

	// output queue and flow control by counting results owed
	logic             m_accept;
	vif_res_t         head;
	logic [CNT_W-1:0] fifo_cnt;
	logic [CNT_W-1:0] pending;

	assign m_accept = m_tvalid && m_tready;

	vif_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_s4),
		.push_data (res_word),
		.pop       (m_accept),
		.head      (head),
		.not_empty (m_tvalid),
		.count     (fifo_cnt)
	);

	assign pending  = fifo_cnt + CNT_W'(res_s1) + CNT_W'(res_s2)
	                + CNT_W'(res_s3) + CNT_W'(res_s4);
	assign s_tready = pending < CNT_W'(OUT_DEPTH);

	assign m_tdata = {2'b00, head.column, head.pixel};
	assign m_tlast = head.row_end;

	// checks
	a_no_overflow : assert property (@(posedge clk) disable iff (!arst_n)
		res_s4 |-> (fifo_cnt < CNT_W'(OUT_DEPTH)) || m_accept)
		else $error("result queue overflow");

	a_credit : assert property (@(posedge clk) disable iff (!arst_n)
		pending <= CNT_W'(OUT_DEPTH))
		else $error("more results owed than queue slots");

	a_row_sat : assert property (@(posedge clk) disable iff (!arst_n)
		int'(row_count_q) <= MAX_TAPS - 1)
		else $error("row count past its limit");

	a_res_origin : assert property (@(posedge clk) disable iff (!arst_n)
		res_s1 |-> $past(s_accept))
		else $error("result started without a taken item");

endmodule

// ===== src/vif_cell.sv =====
// one line cell: a row of the line store, its shift to the next row and one tap product
module vif_cell #(
	parameter int MAX_WIDTH = vif_pkg::MAX_WIDTH_DEF
) (
	input  logic                                   clk,
	input  vif_pkg::vif_cell_ctl_t                 ctl,
	input  logic [$clog2(MAX_WIDTH)-1:0]           rd_addr,
	input  logic [$clog2(MAX_WIDTH)-1:0]           wr_addr,
	input  logic signed [vif_pkg::SAMPLE_W-1:0]    wr_data,
	input  logic signed [vif_pkg::COEFF_W-1:0]     coeff,
	input  logic                                   tap_used,
	output logic signed [vif_pkg::SAMPLE_W-1:0]    rd_data,
	output logic signed [vif_pkg::PROD_W-1:0]      prod_s2
);
	import vif_pkg::*;

	logic signed [SAMPLE_W-1:0] line_mem [MAX_WIDTH];
	logic signed [SAMPLE_W-1:0] rd_q;
	logic signed [PROD_W-1:0]   mul;

	// write-through when the same column is read right behind its write
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			line_mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_q <= (ctl.wr && (wr_addr == rd_addr)) ? wr_data : line_mem[rd_addr];
		end
	end

	assign mul = coeff * rd_q;

	always_ff @(posedge clk) begin
		prod_s2 <= tap_used ? mul : '0;
	end

	assign rd_data = rd_q;

endmodule

// ===== src/vif_out_fifo.sv =====
// small result queue between the filter pipeline and the output stream
module vif_out_fifo #(
	parameter int DEPTH = vif_pkg::OUT_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  vif_pkg::vif_res_t            push_data,
	input  logic                         pop,
	output vif_pkg::vif_res_t            head,
	output logic                         not_empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	import vif_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	vif_res_t        slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign head      = slot_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule
